FILE: rtl/paq_pkg.sv
// shared types and constants for the priority announcement queue
package paq_pkg;

  localparam int unsigned RingDepth      = 16;
  localparam int unsigned RingPtrBits    = $clog2(RingDepth);
  localparam int unsigned PriorityLevels = 4;
  localparam int unsigned PrioBits       = (PriorityLevels > 1) ? $clog2(PriorityLevels) : 1;
  localparam int unsigned WordBits       = 8;
  localparam int unsigned TimeBits       = 32;
  localparam int unsigned CfgBits        = 16;

  localparam logic [PrioBits-1:0] LowestPrio = PrioBits'(PriorityLevels - 1);

  typedef enum logic [1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_WORD   = 2'd1,
    FUNC_ACK    = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_SENDING  = 2'd1,
    ST_COOLDOWN = 2'd2
  } sender_state_e;

  typedef enum logic [1:0] {
    CFG_COOLDOWN = 2'd0,
    CFG_TIMEOUT  = 2'd1,
    CFG_GAP      = 2'd2
  } cfg_index_e;

  localparam logic [CfgBits-1:0] CooldownReset = 16'd1000;
  localparam logic [CfgBits-1:0] TimeoutReset  = 16'd2000;
  localparam logic [CfgBits-1:0] GapReset      = 16'd100;

  typedef struct packed {
    logic [CfgBits-1:0] cooldown_ms;
    logic [CfgBits-1:0] word_timeout_ms;
    logic [CfgBits-1:0] word_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ring_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

FILE: rtl/priority_announcement_queue_unit.sv
// top level: input register, admission and sender control, result register
//
//  channel   ports                                           direction  handshake
//  command   start_i busy_o func_i now_ms_i priority_req_i   in         start_i & !busy_o
//            word_id_i first_word_i
//  result    send_valid_o send_word_id_o                     out        strobe, one cycle
//  config    cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i  in         valid & ready
//
//  an item is accepted in every cycle; busy_o stays low
//  the item is registered, then handled in the next cycle by the admission and
//  sender logic; a sent word is registered and shows on the result ports in the cycle after that
//  the result strobe comes from the result register, which follows the input register
//  reset empties the ring, puts the sender in idle and loads default settings
//  results cannot be stalled by the receiver
module priority_announcement_queue_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    func_i,
  input  logic [31:0]                   now_ms_i,
  input  logic [2:0]                    priority_req_i,
  input  logic [7:0]                    word_id_i,
  input  logic                          first_word_i,
  output logic                          send_valid_o,
  output logic [7:0]                    send_word_id_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [paq_pkg::CfgBits-1:0]   cfg_data_i
);

  paq_pkg::cfg_t       cfg;
  paq_pkg::ring_cmd_t  ring_cmd;
  paq_pkg::ring_stat_t ring_stat;
  logic [paq_pkg::WordBits-1:0] rd_word;

  // input register
  logic                             in_valid_q;
  logic [1:0]                       func_q;
  logic [paq_pkg::TimeBits-1:0]     now_q;
  logic [2:0]                       prio_q;
  logic [paq_pkg::WordBits-1:0]     word_q;
  logic                             first_q;

  // control state
  paq_pkg::sender_state_e           state_q, state_d;
  logic [paq_pkg::TimeBits-1:0]     entry_q, entry_d;
  logic [paq_pkg::TimeBits-1:0]     last_acc_q [paq_pkg::PriorityLevels];
  logic [paq_pkg::TimeBits-1:0]     last_acc_d [paq_pkg::PriorityLevels];
  logic [paq_pkg::PrioBits-1:0]     active_q, active_d;
  logic                             ack_q, ack_d;
  logic                             msg_acc_q, msg_acc_d;

  // result register
  logic                             send_valid_q, send_valid_d;
  logic [paq_pkg::WordBits-1:0]     send_word_q, send_word_d;

  logic [paq_pkg::PrioBits-1:0]     prio_eff;
  logic [paq_pkg::TimeBits-1:0]     since_accept, since_entry;
  logic                             cooldown_hit, sender_busy;

  assign busy_o         = 1'b0;
  assign send_valid_o   = send_valid_q;
  assign send_word_id_o = send_word_q;

  paq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  paq_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (ring_cmd),
    .wr_word_i (word_q),
    .rd_word_o (rd_word),
    .stat_o    (ring_stat)
  );

  // clamp requested priority to the lowest level
  assign prio_eff = (32'(prio_q) > 32'(paq_pkg::LowestPrio)) ?
                    paq_pkg::LowestPrio : paq_pkg::PrioBits'(prio_q);

  assign since_accept = now_q - last_acc_q[prio_eff];
  assign since_entry  = now_q - entry_q;
  assign cooldown_hit = since_accept < paq_pkg::TimeBits'(cfg.cooldown_ms);
  assign sender_busy  = (state_q == paq_pkg::ST_SENDING) ||
                        (state_q == paq_pkg::ST_COOLDOWN);

  always_comb begin
    state_d      = state_q;
    entry_d      = entry_q;
    last_acc_d   = last_acc_q;
    active_d     = active_q;
    ack_d        = ack_q;
    msg_acc_d    = msg_acc_q;
    ring_cmd     = '0;
    send_valid_d = 1'b0;
    send_word_d  = send_word_q;
    if (in_valid_q) begin
      unique case (func_q)
        paq_pkg::FUNC_WORD: begin
          if (first_q) begin
            msg_acc_d = 1'b0;
            if (!cooldown_hit && (!sender_busy || (prio_eff < active_q))) begin
              // higher priority preempts a busy sender by flushing the ring
              ring_cmd.flush       = sender_busy;
              last_acc_d[prio_eff] = now_q;
              active_d             = prio_eff;
              msg_acc_d            = 1'b1;
            end
          end
          ring_cmd.push = msg_acc_d;
        end
        paq_pkg::FUNC_ACK: begin
          ack_d = 1'b1;
        end
        paq_pkg::FUNC_UPDATE: begin
          unique case (state_q)
            paq_pkg::ST_SENDING: begin
              if (ack_q || (since_entry > paq_pkg::TimeBits'(cfg.word_timeout_ms))) begin
                state_d = paq_pkg::ST_COOLDOWN;
                entry_d = now_q;
              end
            end
            paq_pkg::ST_COOLDOWN: begin
              if (since_entry > paq_pkg::TimeBits'(cfg.word_gap_ms)) begin
                state_d = paq_pkg::ST_IDLE;
              end
            end
            default: begin
              state_d = paq_pkg::ST_IDLE;
              if (!ring_stat.empty) begin
                ring_cmd.pop = 1'b1;
                ack_d        = 1'b0;
                state_d      = paq_pkg::ST_SENDING;
                entry_d      = now_q;
                send_valid_d = 1'b1;
                send_word_d  = rd_word;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      state_q      <= paq_pkg::ST_IDLE;
      entry_q      <= '0;
      last_acc_q   <= '{default: '0};
      active_q     <= paq_pkg::LowestPrio;
      ack_q        <= 1'b0;
      msg_acc_q    <= 1'b0;
      send_valid_q <= 1'b0;
    end else begin
      in_valid_q   <= start_i && !busy_o;
      state_q      <= state_d;
      entry_q      <= entry_d;
      last_acc_q   <= last_acc_d;
      active_q     <= active_d;
      ack_q        <= ack_d;
      msg_acc_q    <= msg_acc_d;
      send_valid_q <= send_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q      <= func_i;
    now_q       <= now_ms_i;
    prio_q      <= priority_req_i;
    word_q      <= word_id_i;
    first_q     <= first_word_i;
    send_word_q <= send_word_d;
  end

endmodule

FILE: rtl/paq_cfg.sv
// configuration registers: cooldown, acknowledge timeout and word gap
module paq_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [paq_pkg::CfgBits-1:0] cfg_data_i,
  output paq_pkg::cfg_t              cfg_o
);

  paq_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        paq_pkg::CFG_COOLDOWN: cfg_d.cooldown_ms     = cfg_data_i;
        paq_pkg::CFG_TIMEOUT:  cfg_d.word_timeout_ms = cfg_data_i;
        paq_pkg::CFG_GAP:      cfg_d.word_gap_ms     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cooldown_ms     <= paq_pkg::CooldownReset;
      cfg_q.word_timeout_ms <= paq_pkg::TimeoutReset;
      cfg_q.word_gap_ms     <= paq_pkg::GapReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/paq_ring.sv
// word ring: slot registers with write and read pointers, one slot kept free
module paq_ring (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  paq_pkg::ring_cmd_t           cmd_i,
  input  logic [paq_pkg::WordBits-1:0] wr_word_i,
  output logic [paq_pkg::WordBits-1:0] rd_word_o,
  output paq_pkg::ring_stat_t          stat_o
);

  localparam logic [paq_pkg::RingPtrBits-1:0] LastSlot =
      paq_pkg::RingPtrBits'(paq_pkg::RingDepth - 1);

  logic [paq_pkg::WordBits-1:0]    slot_q [paq_pkg::RingDepth];
  logic [paq_pkg::RingPtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [paq_pkg::RingPtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [paq_pkg::RingPtrBits-1:0] wr_nxt, rd_nxt, wr_addr, wr_base;
  logic                            wr_en;

  function automatic logic [paq_pkg::RingPtrBits-1:0] ptr_inc(
      input logic [paq_pkg::RingPtrBits-1:0] p);
    return (p == LastSlot) ? '0 : p + 1'b1;
  endfunction

  assign wr_nxt       = ptr_inc(wr_ptr_q);
  assign rd_nxt       = ptr_inc(rd_ptr_q);
  assign stat_o.empty = (wr_ptr_q == rd_ptr_q);
  assign stat_o.full  = (wr_nxt == rd_ptr_q);
  assign rd_word_o    = slot_q[rd_ptr_q];

  // a flush empties the ring, so a word pushed with it lands in slot zero
  assign wr_base = cmd_i.flush ? '0 : wr_ptr_q;
  assign wr_addr = wr_base;
  assign wr_en   = cmd_i.push && (cmd_i.flush || !stat_o.full);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (cmd_i.flush) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
    end
    if (wr_en) begin
      wr_ptr_d = ptr_inc(wr_base);
    end
    if (cmd_i.pop) begin
      rd_ptr_d = rd_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_addr] <= wr_word_i;
    end
  end

endmodule

FILE: bench/testbench.sv
// testbench for the priority announcement queue: directed plan, then random phases
`timescale 1ns / 100ps

module testbench;
  import paq_pkg::*;

  localparam logic [1:0] FuncSpare = 2'd3;  // unused function code, block ignores it
  localparam logic [1:0] CfgSpare  = 2'd3;  // register index with no register behind it

  typedef enum int {CHK_MODEL, CHK_NONE, CHK_WORD} check_e;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] now;
    logic [2:0]  prio;
    logic [7:0]  word;
    logic        first;
  } cmd_t;

  typedef struct {
    cmd_t       cmd;
    check_e     how;
    logic [7:0] want;
  } plan_row_t;

  typedef struct {
    logic [15:0] cooldown;
    logic [15:0] timeout;
    logic [15:0] gap;
    int unsigned step_max;
  } phase_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  func_i;
  logic [31:0] now_ms_i;
  logic [2:0]  priority_req_i;
  logic [7:0]  word_id_i;
  logic        first_word_i;
  logic        send_valid_o;
  logic [7:0]  send_word_id_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [CfgBits-1:0] cfg_data_i;

  priority_announcement_queue_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .now_ms_i       (now_ms_i),
    .priority_req_i (priority_req_i),
    .word_id_i      (word_id_i),
    .first_word_i   (first_word_i),
    .send_valid_o   (send_valid_o),
    .send_word_id_o (send_word_id_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // predicted block state
  logic [7:0]    word_slots [RingDepth];
  logic [3:0]    wr_ptr;
  logic [3:0]    rd_ptr;
  sender_state_e sender;
  logic [31:0]   entry_ms;
  logic [31:0]   last_ok_ms [PriorityLevels];
  logic [1:0]    active_prio;
  bit            ack_flag;
  bit            msg_open;
  logic [15:0]   cooldown_set;
  logic [15:0]   timeout_set;
  logic [15:0]   gap_set;

  logic [7:0]  words_due[$];
  int unsigned mismatch_count;
  logic [31:0] clock_ms;
  int unsigned step_max;
  bit          quiet_stretch;
  plan_row_t   plan [24];
  phase_t      phases [8];

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic flag(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", what);
  endtask

  task automatic clear_model();
    foreach (word_slots[i]) word_slots[i] = '0;
    foreach (last_ok_ms[i]) last_ok_ms[i] = '0;
    wr_ptr       = '0;
    rd_ptr       = '0;
    sender       = ST_IDLE;
    entry_ms     = '0;
    active_prio  = LowestPrio;
    ack_flag     = 1'b0;
    msg_open     = 1'b0;
    cooldown_set = CooldownReset;
    timeout_set  = TimeoutReset;
    gap_set      = GapReset;
  endtask

  // returns 1 when the item makes the sender emit a word
  function automatic bit predict_sent_word(input cmd_t c, output logic [7:0] sent);
    logic [1:0]  p;
    logic [3:0]  nxt;
    logic [31:0] since;
    sent = '0;
    p = (c.prio > 3'(LowestPrio)) ? LowestPrio : c.prio[1:0];
    case (c.func)
      FUNC_WORD: begin
        if (c.first) begin
          msg_open = 1'b0;
          since = c.now - last_ok_ms[p];
          if (since < cooldown_set) return 1'b0;
          if (sender != ST_IDLE) begin
            // preemption drops whatever is still queued
            if (p < active_prio) begin
              wr_ptr = '0;
              rd_ptr = '0;
            end else begin
              return 1'b0;
            end
          end
          last_ok_ms[p] = c.now;
          active_prio   = p;
          msg_open      = 1'b1;
        end
        if (msg_open) begin
          nxt = wr_ptr + 4'd1;
          if (nxt != rd_ptr) begin
            word_slots[wr_ptr] = c.word;
            wr_ptr = nxt;
          end
        end
        return 1'b0;
      end
      FUNC_ACK: begin
        ack_flag = 1'b1;
        return 1'b0;
      end
      FUNC_UPDATE: begin
        since = c.now - entry_ms;
        if (sender == ST_SENDING) begin
          if (ack_flag || since > timeout_set) begin
            sender   = ST_COOLDOWN;
            entry_ms = c.now;
          end
          return 1'b0;
        end
        if (sender == ST_COOLDOWN) begin
          if (since > gap_set) sender = ST_IDLE;
          return 1'b0;
        end
        if (wr_ptr == rd_ptr) return 1'b0;
        sent     = word_slots[rd_ptr];
        rd_ptr   = rd_ptr + 4'd1;
        ack_flag = 1'b0;
        sender   = ST_SENDING;
        entry_ms = c.now;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // result checker: a strobe is accepted at the edge that ends its cycle
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && send_valid_o) begin
      if (words_due.size() == 0) begin
        flag($sformatf("unexpected word %02h at %0t", send_word_id_o, $realtime));
      end else begin
        want = words_due.pop_front();
        if (send_word_id_o !== want)
          flag($sformatf("send_word_id: expected %02h, got %02h at %0t", want,
                         send_word_id_o, $realtime));
      end
    end
  end

  task automatic issue(input cmd_t c, input check_e how, input logic [7:0] want);
    logic [7:0] sent;
    bit         has;
    start_i        <= 1'b1;
    func_i         <= c.func;
    now_ms_i       <= c.now;
    priority_req_i <= c.prio;
    word_id_i      <= c.word;
    first_word_i   <= c.first;
    do @(posedge clk_i); while (busy_o);
    has = predict_sent_word(c, sent);
    case (how)
      CHK_MODEL: if (has) words_due.push_back(sent);
      CHK_WORD:  words_due.push_back(want);
      default: ;
    endcase
  endtask

  // random hold-off between items, fields carry junk while start is low
  task automatic pause();
    int unsigned n;
    if (quiet_stretch || $urandom_range(99) >= 30) return;
    n = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    start_i        <= 1'b0;
    func_i         <= 2'($urandom);
    now_ms_i       <= $urandom;
    priority_req_i <= 3'($urandom);
    word_id_i      <= 8'($urandom);
    first_word_i   <= 1'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    start_i <= 1'b0;
    while (words_due.size() != 0 && guard < 200) begin
      @(posedge clk_i);
      guard++;
    end
    if (words_due.size() != 0) begin
      flag($sformatf("%0d expected words never sent", words_due.size()));
      words_due.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_setting(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_COOLDOWN: cooldown_set = val;
      CFG_TIMEOUT:  timeout_set  = val;
      CFG_GAP:      gap_set      = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input phase_t ph, input bit spare_too);
    write_setting(CFG_COOLDOWN, ph.cooldown);
    write_setting(CFG_TIMEOUT, ph.timeout);
    if (spare_too) write_setting(CfgSpare, 16'($urandom));
    write_setting(CFG_GAP, ph.gap);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send(input logic [1:0] f, input logic [2:0] p, input logic [7:0] w,
                      input logic first);
    cmd_t c;
    if ($urandom_range(49) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, step_max);
    c.func  = f;
    c.now   = clock_ms;
    c.prio  = p;
    c.word  = w;
    c.first = first;
    issue(c, CHK_MODEL, 8'h00);
    pause();
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned sent_items;
    int unsigned r;
    int unsigned len;
    sent_items = 0;
    while (sent_items < n_items) begin
      if (sent_items % 50 == 0) quiet_stretch = ($urandom_range(3) == 0);
      r = $urandom_range(99);
      if (r < 38) begin
        send(FUNC_UPDATE, 3'($urandom), 8'($urandom), 1'($urandom));
        sent_items++;
      end else if (r < 50) begin
        send(FUNC_ACK, 3'($urandom), 8'($urandom), 1'($urandom));
        sent_items++;
      end else if (r < 94) begin
        // a whole message, sometimes long enough to overrun the ring
        len = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 4);
        send(FUNC_WORD, 3'($urandom), 8'($urandom), 1'b1);
        sent_items++;
        repeat (len) begin
          if ($urandom_range(9) < 3) begin
            send(FUNC_UPDATE, 3'($urandom), 8'($urandom), 1'b0);
            sent_items++;
          end
          send(FUNC_WORD, 3'($urandom), 8'($urandom), 1'b0);
          sent_items++;
        end
      end else if (r < 97) begin
        send(FuncSpare, 3'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        // stray follow-on word
        send(FUNC_WORD, 3'($urandom), 8'($urandom), 1'b0);
        sent_items++;
      end
    end
  endtask

  function automatic plan_row_t row(input logic [1:0] f, input logic [31:0] now,
                                    input logic [2:0] p, input logic [7:0] w,
                                    input logic first, input check_e how,
                                    input logic [7:0] want);
    plan_row_t pr;
    pr.cmd.func  = f;
    pr.cmd.now   = now;
    pr.cmd.prio  = p;
    pr.cmd.word  = w;
    pr.cmd.first = first;
    pr.how       = how;
    pr.want      = want;
    return pr;
  endfunction

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    func_i         <= FUNC_UPDATE;
    now_ms_i       <= '0;
    priority_req_i <= '0;
    word_id_i      <= '0;
    first_word_i   <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= CFG_COOLDOWN;
    cfg_data_i     <= '0;
    mismatch_count = 0;
    quiet_stretch  = 1'b0;
    clear_model();

    // reset settings: cooldown 1000, timeout 2000, gap 100
    plan[0]  = row(FUNC_UPDATE, 32'd0, 3'd0, 8'h00, 1'b0, CHK_NONE, 8'h00);
    // early message, still inside the cooldown from time zero
    plan[1]  = row(FUNC_WORD, 32'd500, 3'd0, 8'hA5, 1'b1, CHK_NONE, 8'h00);
    plan[2]  = row(FUNC_WORD, 32'd501, 3'd0, 8'h11, 1'b0, CHK_NONE, 8'h00);
    plan[3]  = row(FUNC_UPDATE, 32'd600, 3'd0, 8'h00, 1'b0, CHK_NONE, 8'h00);
    // priority 7 clamps to the lowest level
    plan[4]  = row(FUNC_WORD, 32'd1000, 3'd7, 8'hFF, 1'b1, CHK_MODEL, 8'h00);
    plan[5]  = row(FUNC_WORD, 32'd1001, 3'd0, 8'h00, 1'b0, CHK_MODEL, 8'h00);
    plan[6]  = row(FUNC_UPDATE, 32'd1002, 3'd0, 8'h00, 1'b0, CHK_WORD, 8'hFF);
    // preemption flushes the queued word, the next lower one is refused
    plan[7]  = row(FUNC_WORD, 32'd1003, 3'd1, 8'h3C, 1'b1, CHK_MODEL, 8'h00);
    plan[8]  = row(FUNC_WORD, 32'd1004, 3'd2, 8'h77, 1'b1, CHK_MODEL, 8'h00);
    plan[9]  = row(FUNC_WORD, 32'd1005, 3'd2, 8'h88, 1'b0, CHK_MODEL, 8'h00);
    // timeout and gap boundaries
    plan[10] = row(FUNC_UPDATE, 32'd3002, 3'd0, 8'h00, 1'b0, CHK_NONE, 8'h00);
    plan[11] = row(FUNC_UPDATE, 32'd3003, 3'd0, 8'h00, 1'b0, CHK_NONE, 8'h00);
    plan[12] = row(FUNC_UPDATE, 32'd3104, 3'd0, 8'h00, 1'b0, CHK_NONE, 8'h00);
    plan[13] = row(FUNC_UPDATE, 32'd3105, 3'd0, 8'h00, 1'b0, CHK_WORD, 8'h3C);
    plan[14] = row(FUNC_ACK, 32'd3105, 3'd0, 8'h00, 1'b0, CHK_NONE, 8'h00);
    plan[15] = row(FuncSpare, 32'hFFFF_FFFF, 3'd7, 8'hFF, 1'b1, CHK_NONE, 8'h00);
    plan[16] = row(FUNC_UPDATE, 32'd3106, 3'd0, 8'h00, 1'b0, CHK_MODEL, 8'h00);
    plan[17] = row(FUNC_UPDATE, 32'd3207, 3'd0, 8'h00, 1'b0, CHK_MODEL, 8'h00);
    plan[18] = row(FUNC_UPDATE, 32'd3208, 3'd0, 8'h00, 1'b0, CHK_NONE, 8'h00);
    // time at its top value, then wrapping past zero
    plan[19] = row(FUNC_WORD, 32'hFFFF_FFFF, 3'd0, 8'h81, 1'b1, CHK_MODEL, 8'h00);
    plan[20] = row(FUNC_UPDATE, 32'hFFFF_FFFF, 3'd0, 8'h00, 1'b0, CHK_WORD, 8'h81);
    plan[21] = row(FUNC_UPDATE, 32'd2000, 3'd0, 8'h00, 1'b0, CHK_MODEL, 8'h00);
    plan[22] = row(FUNC_UPDATE, 32'd2101, 3'd0, 8'h00, 1'b0, CHK_MODEL, 8'h00);
    plan[23] = row(FUNC_UPDATE, 32'd2102, 3'd0, 8'h00, 1'b0, CHK_NONE, 8'h00);

    phases[0] = '{CooldownReset, TimeoutReset, GapReset, 300};
    phases[1] = '{16'd0, 16'd0, 16'd0, 3};
    phases[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 20000};
    phases[3] = '{16'd20, 16'd5, 16'd3, 6};
    // long timeout keeps the sender busy so the ring fills up
    phases[4] = '{16'd50, 16'hFFFF, 16'd0, 10};
    phases[5] = '{16'($urandom_range(0, 40)), 16'($urandom_range(0, 30)),
                  16'($urandom_range(0, 30)), 10};
    phases[6] = '{16'($urandom), 16'($urandom), 16'($urandom), 16384};
    phases[7] = '{16'd3, 16'd1, 16'd1, 2};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      issue(plan[i].cmd, plan[i].how, plan[i].want);
      pause();
    end

    clock_ms = 32'd2102;
    foreach (phases[i]) begin
      if (i > 0) begin
        drain();
        load_settings(phases[i], i == 5);
        clock_ms = (i == 7) ? 32'hFFFF_FF00 : $urandom;
      end
      step_max = phases[i].step_max;
      run_random(245);
    end
    drain();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
